// ===== hdl/lor_pkg.sv =====
`default_nettype none

package lor_pkg;

    localparam int COORD_W     = 10;  // endpoint coordinate width
    localparam int YS_W        = 12;  // walking y, two's complement, spans -1023..2046
    localparam int CMP_W       = 14;  // compare width for bounds checks against the grid side
    localparam int COUNT_W     = 21;  // overlap counter width
    localparam int HIT_W       = 2;   // per-cell hit count width
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [HIT_W-1:0]   HIT_LIMIT = HIT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // per-step y movement
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_INC,
        STEP_DEC
    } step_t;

    // classified segment: start cell, number of extra steps, step direction, skip flag
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] span;
        logic               step_x;
        step_t              step_y;
        logic               skip;
    } seg_desc_t;

endpackage

`default_nettype wire

// ===== hdl/lor_front.sv =====
`default_nettype none

module lor_front
    import lor_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [COORD_W-1:0] s_start_x,
    input  wire logic [COORD_W-1:0] s_start_y,
    input  wire logic [COORD_W-1:0] s_end_x,
    input  wire logic [COORD_W-1:0] s_end_y,
    input  wire logic               grid_ready,
    input  wire logic               q_full,
    output logic                    push,
    output seg_desc_t               push_desc
);

    logic with_diag_reg;

    logic               is_vert;
    logic               is_horiz;
    logic               x_fwd;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] y_hi;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] far_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            with_diag_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            with_diag_reg <= cfg_wr_data;
        end
    end

    assign s_ready = grid_ready && !q_full;
    assign push    = s_valid && s_ready;

    assign is_vert  = (s_start_x == s_end_x);
    assign is_horiz = (s_start_y == s_end_y);
    assign x_fwd    = (s_start_x < s_end_x);
    assign y_lo     = (s_start_y < s_end_y) ? s_start_y : s_end_y;
    assign y_hi     = (s_start_y < s_end_y) ? s_end_y : s_start_y;
    assign x_lo     = x_fwd ? s_start_x : s_end_x;
    assign x_hi     = x_fwd ? s_end_x : s_start_x;
    assign far_y    = x_fwd ? s_end_y : s_start_y;

    always_comb begin
        push_desc        = '0;
        push_desc.step_y = STEP_NONE;
        if (is_vert) begin
            // single points land here too
            push_desc.x0     = s_start_x;
            push_desc.y0     = y_lo;
            push_desc.span   = y_hi - y_lo;
            push_desc.step_y = STEP_INC;
        end else if (is_horiz) begin
            push_desc.x0     = x_lo;
            push_desc.y0     = s_start_y;
            push_desc.span   = x_hi - x_lo;
            push_desc.step_x = 1'b1;
        end else if (with_diag_reg) begin
            // walk from the left endpoint
            push_desc.x0     = x_lo;
            push_desc.y0     = x_fwd ? s_start_y : s_end_y;
            push_desc.span   = x_hi - x_lo;
            push_desc.step_x = 1'b1;
            push_desc.step_y = (far_y > (x_fwd ? s_start_y : s_end_y)) ? STEP_INC : STEP_DEC;
        end else begin
            push_desc.skip   = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lor_queue.sv =====
`default_nettype none

module lor_queue
    import lor_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  var  seg_desc_t push_desc,
    output logic           q_full,
    output logic           q_valid,
    output seg_desc_t      q_desc,
    input  wire logic      pop
);

    seg_desc_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    logic do_push;
    logic do_pop;

    assign q_full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_desc  = slot_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lor_back.sv =====
`default_nettype none

module lor_back
    import lor_pkg::*;
#(
    parameter int GRID_SIDE = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  var  seg_desc_t          q_desc,
    output logic                    pop,
    output logic                    grid_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COUNT_W-1:0]      m_overlap_count,
    output logic                    m_skipped
);

    localparam int              DEPTH     = GRID_SIDE * GRID_SIDE;
    localparam int              AW        = $clog2(DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0]   SIDE_A    = AW'(GRID_SIDE);
    localparam logic [CMP_W-1:0] SIDE_C   = CMP_W'(GRID_SIDE);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    logic [HIT_W-1:0] grid_mem [DEPTH];

    state_t             st_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [COORD_W-1:0] cur_x_reg;
    logic [YS_W-1:0]    cur_y_reg;
    logic [COORD_W-1:0] left_reg;
    logic               step_x_reg;
    step_t              step_y_reg;
    logic               skip_reg;
    logic               p1_vld_reg;
    logic [AW-1:0]      p1_addr_reg;
    logic [HIT_W-1:0]   rd_data_reg;
    logic               fwd_vld_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [HIT_W-1:0]   fwd_data_reg;
    logic [COUNT_W-1:0] total_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_skip_reg;

    logic               cell_in;
    logic [AW-1:0]      cell_addr;
    logic [HIT_W-1:0]   hit_old;
    logic [HIT_W-1:0]   hit_new;
    logic               reach;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [HIT_W-1:0]   mem_wdata;
    logic               out_free;
    logic               result_load;

    // bounds check of the current cell; its address is written only when inside
    assign cell_in = ({{(CMP_W-COORD_W){1'b0}}, cur_x_reg} < SIDE_C)
                  && !cur_y_reg[YS_W-1]
                  && ({{(CMP_W-YS_W){1'b0}}, cur_y_reg} < SIDE_C);
    assign cell_addr = AW'(cur_x_reg) * SIDE_A + AW'(cur_y_reg);

    // cell written last cycle is not yet visible in the registered read
    assign hit_old = (fwd_vld_reg && (fwd_addr_reg == p1_addr_reg)) ? fwd_data_reg
                                                                    : rd_data_reg;
    assign hit_new = (hit_old < HIT_LIMIT) ? (hit_old + HIT_W'(1)) : hit_old;
    assign reach   = p1_vld_reg && (hit_old == (HIT_LIMIT - HIT_W'(1)));

    assign mem_we    = (st_reg == ST_CLEAR) || p1_vld_reg;
    assign mem_waddr = (st_reg == ST_CLEAR) ? clr_addr_reg : p1_addr_reg;
    assign mem_wdata = (st_reg == ST_CLEAR) ? '0 : hit_new;

    assign out_free    = !m_valid_reg || m_ready;
    // last cell's update lands before the count is sampled
    assign result_load = (st_reg == ST_DRAIN) && !p1_vld_reg && out_free;
    assign pop         = (st_reg == ST_IDLE) && q_valid;
    assign grid_ready  = (st_reg != ST_CLEAR);

    assign m_valid         = m_valid_reg;
    assign m_overlap_count = m_count_reg;
    assign m_skipped       = m_skip_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[cell_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_CLEAR;
            clr_addr_reg <= '0;
            p1_vld_reg   <= 1'b0;
            fwd_vld_reg  <= 1'b0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_vld_reg   <= (st_reg == ST_WALK) && cell_in;
            p1_addr_reg  <= cell_addr;
            fwd_vld_reg  <= p1_vld_reg;
            fwd_addr_reg <= p1_addr_reg;
            fwd_data_reg <= hit_new;

            if (reach && (total_reg != COUNT_MAX)) begin
                total_reg <= total_reg + COUNT_W'(1);
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (st_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == LAST_ADDR) begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        cur_x_reg  <= q_desc.x0;
                        cur_y_reg  <= {{(YS_W-COORD_W){1'b0}}, q_desc.y0};
                        left_reg   <= q_desc.span;
                        step_x_reg <= q_desc.step_x;
                        step_y_reg <= q_desc.step_y;
                        skip_reg   <= q_desc.skip;
                        st_reg     <= q_desc.skip ? ST_DRAIN : ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (left_reg == '0) begin
                        st_reg <= ST_DRAIN;
                    end else begin
                        left_reg  <= left_reg - COORD_W'(1);
                        cur_x_reg <= cur_x_reg + {{(COORD_W-1){1'b0}}, step_x_reg};
                        case (step_y_reg)
                            STEP_INC: cur_y_reg <= cur_y_reg + YS_W'(1);
                            STEP_DEC: cur_y_reg <= cur_y_reg - YS_W'(1);
                            default:  cur_y_reg <= cur_y_reg;
                        endcase
                    end
                end
                ST_DRAIN: begin
                    if (result_load) begin
                        m_count_reg <= total_reg;
                        m_skip_reg  <= skip_reg;
                        st_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/line_overlap_rasterizer_unit.sv =====
// Line overlap rasterizer: marks grid cells along line segments and counts
// cells hit by two or more segments.
//
// s_ channel: one request per segment (start_x/start_y, end_x/end_y).
// m_ channel: one request per segment, in order: running overlap count and a
//   flag set when a non-axis segment was dropped because diagonal mode is off.
// cfg_wr_en/cfg_wr_data: with_diagonal bit; the user writes it only while idle,
//   and the block itself does not enforce this.
// Throughput: one grid cell read-modify-written per cycle while walking; a
//   segment holds the walker for its pop, its cells and the drain, which also
//   waits for a free output register; a skipped segment takes pop and drain only.
// Path: accept -> queue -> walker pop -> cells -> drain -> m_valid.
// Reset: aresetn clears control state and starts a clearing pass over the
//   GRID_SIDE*GRID_SIDE cell memory, one cell per cycle; s_ready stays low
//   during the pass. Config writes are taken during the pass.
// Stall: a 4-deep segment queue sits between classifier and walker, so
//   requests keep flowing while a result waits in the output register; when
//   m_ready is low the walker holds its finished result and the queue fills.
`default_nettype none

module line_overlap_rasterizer_unit
    import lor_pkg::*;
#(
    parameter int GRID_SIDE = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [COORD_W-1:0] s_start_x,
    input  wire logic [COORD_W-1:0] s_start_y,
    input  wire logic [COORD_W-1:0] s_end_x,
    input  wire logic [COORD_W-1:0] s_end_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COUNT_W-1:0]      m_overlap_count,
    output logic                    m_skipped
);

    logic      grid_ready;
    logic      q_full;
    logic      push;
    seg_desc_t push_desc;
    logic      q_valid;
    seg_desc_t q_desc;
    logic      pop;

    // classifier: axis / diagonal / skipped, start cell and step direction
    lor_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .grid_ready  (grid_ready),
        .q_full      (q_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    // decouples the classifier from the cell walker
    lor_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .q_desc    (q_desc),
        .pop       (pop)
    );

    // cell walker: memory sweep, read-modify-write pipe, counter, result reg
    lor_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_desc          (q_desc),
        .pop             (pop),
        .grid_ready      (grid_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_overlap_count (m_overlap_count),
        .m_skipped       (m_skipped)
    );

endmodule

`default_nettype wire
